// ===== src/rau_pkg.sv =====
// Package: payload types, state encoding and command/status structs for the rational unit.
`default_nettype none
package rau_pkg;

  localparam int DefOperandWidth = 32;
  localparam int MagWidth = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] num_a;
    logic [30:0]        den_a;
    logic signed [31:0] num_b;
    logic [30:0]        den_b;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result_num;
    logic [62:0]        result_den;
    logic               div_by_zero;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_COMBINE,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // capture request
    logic mul1;      // first product pair
    logic mul2;      // second product pair
    logic combine;   // form magnitude and denominator
    logic gcd_step;  // one binary-gcd step
    logic div_start; // start a division
    logic div_step;  // one restoring-division step
    logic div_sel;   // 0: divide magnitude, 1: divide denominator
    logic finish;    // apply sign and zero rule
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic err;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/rational_arithmetic_unit_top.sv =====
// Top level: rational add/subtract/multiply/divide with gcd reduction.
`default_nettype none
// One request at a time. A request runs through the cross products and
// combine, a binary gcd that takes one shift or subtract step per cycle,
// then two 64-step restoring divisions by the gcd (numerator, then
// denominator), a finish state and the output state. An error request
// (zero denominator, or divide by a zero fraction) skips the gcd and
// divisions and returns 0/1 with div_by_zero set. Zero results come out
// as 0/1. The result stays on rsp until out_ready takes it.
module rational_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = rau_pkg::DefOperandWidth
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rau_pkg::req_t req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rau_pkg::rsp_t      rsp
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk, .req, .cmd, .sts, .rsp
  );

  // Never accept a new request while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");

  // A reported result has a nonzero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rsp.result_den != '0) else $error("zero denominator");

  // An error result is always 0/1.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rsp.div_by_zero) |-> (rsp.result_num == '0 && rsp.result_den == 63'd1))
    else $error("error result not 0/1");

endmodule
`default_nettype wire

// ===== src/rau_datapath.sv =====
// Datapath: products, combine, binary gcd and serial exact division.
`default_nettype none
module rau_datapath #(
  parameter int OPERAND_WIDTH = rau_pkg::DefOperandWidth
) (
  input  wire logic          clk,
  input  wire rau_pkg::req_t req,
  input  wire rau_pkg::cmd_t cmd,
  output rau_pkg::sts_t      sts,
  output rau_pkg::rsp_t      rsp
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  logic [1:0]          op;
  logic                sa, sb;
  logic [W-1:0]        ma, mb;
  logic [W-2:0]        da, db;
  logic                err;
  logic [63:0]         p1, p2, p3; // products
  logic                neg;
  logic [63:0]         mag, den;
  logic [63:0]         gx, gy;     // gcd working pair
  logic [6:0]          gshift;
  logic [63:0]         g;
  logic [63:0]         dquo, drem, dnum;
  logic [6:0]          dcnt;
  logic [63:0]         qmag;

  logic [W-1:0] raw_a, raw_b;
  logic [W-2:0] raw_da, raw_db;
  assign raw_a  = req.num_a[W-1:0];
  assign raw_b  = req.num_b[W-1:0];
  assign raw_da = req.den_a[W-2:0];
  assign raw_db = req.den_b[W-2:0];

  // First pass always forms ma*db; the second pass depends on the operation.
  logic [W-1:0] mul_x, mul_y;
  logic [63:0]  mul_p;
  always_comb begin
    mul_x = ma;
    mul_y = {1'b0, db};
    if (cmd.mul2) begin
      case (op)
        OP_DIV: begin
          mul_x = {1'b0, da};
          mul_y = mb;
        end
        OP_MUL:  mul_y = mb;
        default: begin
          mul_x = mb;
          mul_y = {1'b0, da};
        end
      endcase
    end
  end
  assign mul_p = 64'(mul_x) * 64'(mul_y);

  logic        s2;
  logic [63:0] comb_mag, den_prod;
  logic        comb_neg;
  assign den_prod = 64'(da) * 64'(db);
  always_comb begin
    s2 = (op == OP_SUB) ? !sb : sb;
    comb_neg = sa ^ sb;
    comb_mag = p2;
    case (op)
      OP_ADD, OP_SUB: begin
        if (sa == s2) begin
          comb_mag = p1 + p2; comb_neg = sa;
        end else if (p1 >= p2) begin
          comb_mag = p1 - p2; comb_neg = sa;
        end else begin
          comb_mag = p2 - p1; comb_neg = s2;
        end
      end
      OP_MUL:  comb_mag = p2;
      default: comb_mag = p1;
    endcase
  end

  // Binary gcd: done when gy reaches zero; result gx << gshift.
  logic [63:0] dif;
  assign dif = (gx > gy) ? gx - gy : gy - gx;

  logic [64:0] trial;
  assign trial = {drem, dnum[63]} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req.operation;
      sa  <= raw_a[W-1];
      sb  <= raw_b[W-1];
      ma  <= raw_a[W-1] ? (~raw_a + 1'b1) : raw_a;
      mb  <= raw_b[W-1] ? (~raw_b + 1'b1) : raw_b;
      da  <= raw_da;
      db  <= raw_db;
      err <= (raw_da == '0) || (raw_db == '0) ||
             (req.operation == OP_DIV && raw_b == '0);
    end
    if (cmd.mul1) p1 <= mul_p;
    if (cmd.mul2) begin
      p2 <= mul_p;
      if (op == OP_DIV) p3 <= mul_p;
    end
    if (cmd.combine) begin
      mag    <= comb_mag;
      den    <= (op == OP_DIV) ? p3 : den_prod;
      neg    <= comb_neg;
      gx     <= comb_mag;
      gy     <= (op == OP_DIV) ? p3 : den_prod;
      gshift <= '0;
    end
    if (cmd.gcd_step) begin
      if (gx == '0) begin
        gx <= gy; gy <= '0;
      end else if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1; gy <= gy >> 1; gshift <= gshift + 7'd1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else begin
        gx <= (gx < gy) ? gx : gy;
        gy <= dif >> 1;
      end
    end
    if (cmd.div_start) begin
      if (!cmd.div_sel) g <= gx << gshift;
      dnum <= cmd.div_sel ? den : mag;
      drem <= '0;
      dquo <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      dnum <= dnum << 1;
      dcnt <= dcnt + 7'd1;
      if (!trial[64]) begin
        drem <= trial[63:0]; dquo <= {dquo[62:0], 1'b1};
      end else begin
        drem <= {drem[62:0], dnum[63]}; dquo <= {dquo[62:0], 1'b0};
      end
    end
    if (cmd.finish && !cmd.div_sel) qmag <= dquo;
    if (cmd.finish && cmd.div_sel) begin
      if (err || qmag == '0) begin
        rsp.result_num <= '0;
        rsp.result_den <= 63'd1;
      end else begin
        rsp.result_num <= neg ? (64'd0 - qmag) : qmag;
        rsp.result_den <= dquo[62:0];
      end
      rsp.div_by_zero <= err;
    end
  end

  assign sts.err      = err;
  assign sts.gcd_done = (gy == '0);
  assign sts.div_done = (dcnt == 7'd64);

endmodule
`default_nettype wire

// ===== src/rau_ctrl.sv =====
// Controller: sequences one request through products, gcd and two divisions.
`default_nettype none
module rau_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire rau_pkg::sts_t sts,
  output rau_pkg::cmd_t      cmd
);
  import rau_pkg::*;

  state_t state, state_next;
  logic   sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_MUL1;
      ST_MUL1:    state_next = ST_MUL2;
      ST_MUL2:    state_next = ST_COMBINE;
      ST_COMBINE: state_next = sts.err ? ST_FINISH : ST_GCD;
      ST_GCD:     if (sts.gcd_done) begin
        state_next = ST_DIV_NUM; sel_next = 1'b0;
      end
      ST_DIV_NUM: state_next = ST_DIV_DEN;
      ST_DIV_DEN: if (sts.div_done) begin
        if (sel) state_next = ST_FINISH;
        else begin
          state_next = ST_DIV_NUM; sel_next = 1'b1;
        end
      end
      ST_FINISH:  state_next = ST_OUT;
      ST_OUT:     if (out_ready) begin
        state_next = ST_IDLE; sel_next = 1'b0;
      end
      default:    state_next = ST_IDLE;
    endcase
    if (state == ST_COMBINE && sts.err) sel_next = 1'b1;
  end

  // ST_DIV_NUM starts a division, ST_DIV_DEN steps it; sel picks the operand.
  always_comb begin
    cmd       = '0;
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    cmd.load  = (state == ST_IDLE) && in_valid;
    cmd.div_sel = sel;
    case (state)
      ST_MUL1:    cmd.mul1 = 1'b1;
      ST_MUL2:    cmd.mul2 = 1'b1;
      ST_COMBINE: cmd.combine = 1'b1;
      ST_GCD:     cmd.gcd_step = !sts.gcd_done;
      ST_DIV_NUM: cmd.div_start = 1'b1;
      ST_DIV_DEN: begin
        cmd.div_step = !sts.div_done;
        cmd.finish   = sts.div_done && !sel;
      end
      ST_FINISH:  cmd.finish = 1'b1;
      default:    cmd = cmd;
    endcase
  end

endmodule
`default_nettype wire

// ===== dv/tb_rational_arithmetic_unit_top.sv =====
// Testbench for the rational arithmetic unit: random and directed fraction requests.
`timescale 1ns / 100ps
`default_nettype none
module tb_rational_arithmetic_unit_top;
  import rau_pkg::*;

  // Expected-result store with its own fraction predictor.
  class fraction_scoreboard;
    rsp_t pending[$];
    int   errors;

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    function automatic rsp_t reduce(req_t q);
      rsp_t        e;
      logic        sa, sb, s2, neg;
      logic [63:0] ma, mb, da, db, m1, m2, mag, den, g;
      sa = q.num_a[31];
      sb = q.num_b[31];
      ma = sa ? 64'(-{32'b0, q.num_a} & 64'hFFFF_FFFF) : {32'b0, q.num_a};
      mb = sb ? 64'(-{32'b0, q.num_b} & 64'hFFFF_FFFF) : {32'b0, q.num_b};
      da = {33'b0, q.den_a};
      db = {33'b0, q.den_b};
      e.result_num = 0;
      e.result_den = 1;
      e.div_by_zero = 1'b1;
      if (da == 0 || db == 0 || (op_t'(q.operation) == OP_DIV && mb == 0)) return e;
      case (op_t'(q.operation))
        OP_ADD, OP_SUB: begin
          m1 = ma * db;
          m2 = mb * da;
          s2 = (op_t'(q.operation) == OP_SUB) ? !sb : sb;
          if (sa == s2) begin
            mag = m1 + m2;
            neg = sa;
          end else if (m1 >= m2) begin
            mag = m1 - m2;
            neg = sa;
          end else begin
            mag = m2 - m1;
            neg = s2;
          end
          den = da * db;
        end
        OP_MUL: begin
          mag = ma * mb;
          den = da * db;
          neg = sa ^ sb;
        end
        default: begin
          mag = ma * db;
          den = da * mb;
          neg = sa ^ sb;
        end
      endcase
      g = gcd64(mag, den);
      mag = mag / g;
      den = den / g;
      if (mag == 0) begin
        neg = 1'b0;
        den = 1;
      end
      e.result_num = neg ? -mag : mag;
      e.result_den = den[62:0];
      e.div_by_zero = 1'b0;
      return e;
    endfunction

    // Print one line per mismatch and count it.
    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    function void note_request(req_t q);
      pending.push_back(reduce(q));
    endfunction

    task check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding", '0, '0);
        return;
      end
      want = pending.pop_front();
      if (got.result_num !== want.result_num)
        report_mismatch("result_num", got.result_num, want.result_num);
      if (got.result_den !== want.result_den)
        report_mismatch("result_den", 64'(got.result_den), 64'(want.result_den));
      if (got.div_by_zero !== want.div_by_zero)
        report_mismatch("div_by_zero", 64'(got.div_by_zero), 64'(want.div_by_zero));
    endtask
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  req_t  req = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  rsp_t  rsp;
  int    idle_cycles = 0;
  bit    sending_done = 1'b0;
  fraction_scoreboard fractions = new();

  localparam int WatchdogLimit = 20000;

  always #2 clk = ~clk;

  rational_arithmetic_unit_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .req(req),
    .out_valid(out_valid), .out_ready(out_ready), .rsp(rsp)
  );

  // Short gaps most of the time, occasionally a long one, sometimes none.
  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Note requests and check results at the same edge the DUT sees them.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) fractions.note_request(req);
      if (out_valid && out_ready) fractions.check_result(rsp);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall at random, with stretches of always-ready.
  initial begin : receiver
    int g;
    @(posedge clk iff !rst);
    forever begin
      g = gap_length();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Hold the request until accepted, then drop valid for an optional gap.
  task automatic send_request(req_t q);
    int g;
    in_valid <= 1'b1;
    req <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = gap_length();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic req_t make_request(op_t op, logic [31:0] na, logic [30:0] da,
                                        logic [31:0] nb, logic [30:0] db);
    req_t q;
    q.operation = op;
    q.num_a = na;
    q.den_a = da;
    q.num_b = nb;
    q.den_b = db;
    return q;
  endfunction

  // Random numerators: full range, small values, extremes, or 16-bit values.
  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom & 32'h0000_FFFF;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 9))
      0: return 31'h7FFF_FFFF;
      1: return 31'd0; // zero denominator takes the error path
      2, 3: return 31'($urandom_range(1, 12));
      4: return 31'($urandom & 32'h0000_FFFF);
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin : sender
    req_t q;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: every operation, extremes, zero result, both error cases.
    send_request(make_request(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3));
    send_request(make_request(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2));
    send_request(make_request(OP_SUB, 32'd1, 31'd3, 32'd1, 31'd2));
    send_request(make_request(OP_MUL, -32'sd4, 31'd6, 32'd3, 31'd8));
    send_request(make_request(OP_DIV, 32'd2, 31'd3, -32'sd4, 31'd9));
    send_request(make_request(OP_DIV, 32'd5, 31'd7, 32'd0, 31'd1));
    send_request(make_request(OP_MUL, 32'd0, 31'd5, 32'd9, 31'd4));
    send_request(make_request(OP_ADD, 32'd3, 31'd0, 32'd1, 31'd1));
    send_request(make_request(OP_MUL, 32'd3, 31'd1, 32'd1, 31'd0));
    send_request(make_request(OP_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1));
    send_request(make_request(OP_ADD, 32'h8000_0000, 31'h7FFF_FFFF,
                              32'h8000_0000, 31'h7FFF_FFFE));
    send_request(make_request(OP_SUB, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                              32'h8000_0000, 31'd1));
    send_request(make_request(OP_DIV, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF,
                              31'h7FFF_FFFF));
    send_request(make_request(OP_DIV, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                              32'hFFFF_FFFF, 31'd1));
    send_request(make_request(OP_ADD, -32'sd1, 31'd2, 32'd1, 31'd2));
    send_request(make_request(OP_MUL, 32'hFFFF_FFFF, 31'h5555_5555, 32'hAAAA_AAAA,
                              31'h2AAA_AAAA));
    // Hold off until the unit has drained everything.
    in_valid <= 1'b0;
    @(posedge clk);
    while (fractions.pending.size() != 0) @(posedge clk);
    @(posedge clk);
    for (int n = 0; n < 540; n++) begin
      q = make_request(op_t'($urandom_range(0, 3)), pick_num(), pick_den(),
                       pick_num(), pick_den());
      if ($urandom_range(0, 19) == 0 && q.operation == OP_DIV) q.num_b = '0;
      send_request(q);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    sending_done = 1'b1;
  end

  initial begin : finish_check
    @(posedge clk);
    while (!sending_done || fractions.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fractions.errors == 0 && fractions.pending.size() == 0)
      $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end
endmodule
`default_nettype wire
